// ===== rtl/abc_pkg.sv =====
// ----------------------------------------------------------------------------
// AES block cipher package
// S-box tables, round constants and GF(2^8) helpers shared by the round cells.
// ----------------------------------------------------------------------------
package abc_pkg;

  localparam int unsigned MaxRounds = 14;
  localparam int unsigned KeyWords  = 60;

  typedef logic [127:0] block_t;
  typedef logic [31:0]  word_t;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE  = 3'd0,
    CFG_DIRECTION = 3'd1,
    CFG_KEY_WORD0 = 3'd2,
    CFG_KEY_WORD1 = 3'd3,
    CFG_KEY_WORD2 = 3'd4,
    CFG_KEY_WORD3 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic       valid;
    logic       decrypt;
    logic [3:0] nr;
  } ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] sbyte(input block_t s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic block_t round_fwd(input block_t s, input logic last);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[sbyte(s, r + 4*((c+r) % 4))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = sbyte(t, 4*c); a1 = sbyte(t, 4*c+1);
        a2 = sbyte(t, 4*c+2); a3 = sbyte(t, 4*c+3);
        t[127-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                             xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00)
         ^ (m[3] ? a8 : 8'h00);
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r + 4*((c+r) % 4)) -: 8] = inv_sbox(sbyte(s, r+4*c));
      end
    end
    return t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sbyte(s, 4*c); a1 = sbyte(s, 4*c+1);
      a2 = sbyte(s, 4*c+2); a3 = sbyte(s, 4*c+3);
      t[127-32*c -: 32] = {
        gm(a0,4'he) ^ gm(a1,4'hb) ^ gm(a2,4'hd) ^ gm(a3,4'h9),
        gm(a0,4'h9) ^ gm(a1,4'he) ^ gm(a2,4'hb) ^ gm(a3,4'hd),
        gm(a0,4'hd) ^ gm(a1,4'h9) ^ gm(a2,4'he) ^ gm(a3,4'hb),
        gm(a0,4'hb) ^ gm(a1,4'hd) ^ gm(a2,4'h9) ^ gm(a3,4'he)};
    end
    return t;
  endfunction

endpackage

// ===== rtl/abc_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the key registers into round keys, one word per cycle after a write.
// ----------------------------------------------------------------------------
module abc_key_sched (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic [1:0]            key_size,
  input  logic [255:0]          key,
  output abc_pkg::word_t        rk_words [abc_pkg::KeyWords],
  output logic [3:0]            nr
);
  logic [2:0] nk;
  logic [5:0] idx_r, idx_nxt;
  logic [2:0] mod_r, mod_nxt;
  logic [3:0] rc_r, rc_nxt;
  abc_pkg::word_t words_r [abc_pkg::KeyWords];
  abc_pkg::word_t prev, tmp, far;

  always_comb begin
    priority if (key_size[1]) begin
      nk = 3'd7; nr = 4'd14;
    end else if (key_size[0]) begin
      nk = 3'd5; nr = 4'd12;
    end else begin
      nk = 3'd3; nr = 4'd10;
    end
  end

  // mod_r counts i % nk with nk stored minus one
  always_comb begin
    prev = words_r[idx_r - 6'd1];
    far  = words_r[idx_r - {2'b00, nk} - 6'd1];
    tmp  = prev;
    if (mod_r == 3'd0) begin
      tmp = abc_pkg::sub_word({prev[23:0], prev[31:24]})
          ^ {abc_pkg::RCON[rc_r], 24'h0};
    end else if (nk == 3'd7 && mod_r == 3'd4) begin
      tmp = abc_pkg::sub_word(prev);
    end
    idx_nxt = (idx_r == 6'(abc_pkg::KeyWords)) ? idx_r : idx_r + 6'd1;
    mod_nxt = (mod_r == nk) ? 3'd0 : mod_r + 3'd1;
    rc_nxt  = (mod_r != 3'd0) ? rc_r : ((rc_r == 4'd10) ? 4'd0 : rc_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      idx_r <= {3'b000, nk} + 6'd1;
      mod_r <= 3'd0;
      rc_r  <= 4'd1;
    end else if (idx_r != 6'(abc_pkg::KeyWords)) begin
      idx_r <= idx_nxt;
      mod_r <= mod_nxt;
      rc_r  <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < 8; i++) words_r[i] <= key[255-32*i -: 32];
    end else if (idx_r != 6'(abc_pkg::KeyWords)) begin
      words_r[idx_r[5:0]] <= tmp ^ far;
    end
  end

  assign rk_words = words_r;
endmodule

// ===== rtl/abc_round_cell.sv =====
// ----------------------------------------------------------------------------
// AES round cell
// One round of encryption or decryption, or a pass-through for rounds beyond nr;
// hands the state to the next cell.
module abc_round_cell #(
  parameter int unsigned Round = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  abc_pkg::ctl_t   ctl_in,
  input  abc_pkg::block_t state_in,
  input  abc_pkg::block_t key_fwd,
  input  abc_pkg::block_t key_inv,
  output abc_pkg::ctl_t   ctl_out,
  output abc_pkg::block_t state_out
);
  abc_pkg::ctl_t   ctl_r;
  abc_pkg::block_t state_r, state_nxt, inv_t;
  logic            active, last;

  always_comb begin
    active = (4'(Round) <= ctl_in.nr);
    last   = (4'(Round) == ctl_in.nr);
    inv_t  = abc_pkg::inv_sub_shift(state_in) ^ key_inv;
    state_nxt = state_in;
    if (active) begin
      if (ctl_in.decrypt) begin
        state_nxt = last ? inv_t : abc_pkg::inv_mix(inv_t);
      end else begin
        state_nxt = abc_pkg::round_fwd(state_in, last) ^ key_fwd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    state_r <= state_nxt;
  end

  assign ctl_out   = ctl_r;
  assign state_out = state_r;
endmodule

// ===== rtl/aes_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// AES block cipher top
// AES-128/192/256 ECB core built as a chain of fourteen round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_size, direction and key words on the cfg_ port while idle.
//   Each write restarts the key schedule, which builds one round key word
//   per cycle; allow 60 cycles after the last write before the first beat.
//   A beat is accepted on start high with busy low; busy is always low, so
//   one block enters every cycle.
//   Each block passes an input key-add stage and fourteen round cells; the
//   result shows on out_result_hi/lo with out_valid high for one cycle as
//   it leaves the last cell. Shorter keys pass unused cells unchanged.
//   Throughput: one block per cycle, set by the fully unrolled round chain.
//   Reset clears configuration to zero and empties the chain. The receiver
//   cannot stall; results are never held.
// ----------------------------------------------------------------------------
module aes_block_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int unsigned Nr = abc_pkg::MaxRounds;

  logic [1:0]   key_size_r;
  logic         direction_r;
  logic [255:0] key_r;
  logic         restart;
  logic [3:0]   nr;
  abc_pkg::word_t  rk_words [abc_pkg::KeyWords];
  abc_pkg::block_t rk [Nr+1];
  abc_pkg::block_t st [Nr+1];
  abc_pkg::ctl_t   ctl [Nr+1];
  abc_pkg::block_t in_blk, first_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r  <= '0;
      direction_r <= 1'b0;
      key_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abc_pkg::CFG_KEY_SIZE:  key_size_r  <= cfg_data[1:0];
        abc_pkg::CFG_DIRECTION: direction_r <= cfg_data[0];
        abc_pkg::CFG_KEY_WORD0: key_r[255:192] <= cfg_data;
        abc_pkg::CFG_KEY_WORD1: key_r[191:128] <= cfg_data;
        abc_pkg::CFG_KEY_WORD2: key_r[127:64]  <= cfg_data;
        abc_pkg::CFG_KEY_WORD3: key_r[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) restart <= 1'b1;
    else restart <= cfg_we;
  end

  abc_key_sched u_key (
    .clk(clk), .rst_n(rst_n), .restart(restart), .key_size(key_size_r),
    .key(key_r), .rk_words(rk_words), .nr(nr)
  );

  for (genvar g = 0; g <= Nr; g++) begin : g_rk
    assign rk[g] = {rk_words[4*g], rk_words[4*g+1], rk_words[4*g+2], rk_words[4*g+3]};
  end

  assign busy   = 1'b0;
  assign in_blk = {in_block_hi, in_block_lo};

  always_comb begin
    first_key = rk[0];
    if (direction_r) first_key = rk[nr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl[0] <= '0;
    end else begin
      ctl[0] <= '{valid: start, decrypt: direction_r, nr: nr};
    end
    st[0] <= in_blk ^ first_key;
  end

  // decrypt cell g uses round key nr-g
  for (genvar g = 1; g <= Nr; g++) begin : g_cell
    abc_pkg::block_t kinv;
    always_comb begin
      kinv = rk[0];
      for (int j = 0; j <= Nr; j++) begin
        if (4'(j) + 4'(g) == ctl[g-1].nr) kinv = rk[j];
      end
    end
    abc_round_cell #(.Round(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl_in(ctl[g-1]), .state_in(st[g-1]),
      .key_fwd(rk[g]), .key_inv(kinv), .ctl_out(ctl[g]), .state_out(st[g])
    );
  end

  assign out_valid     = ctl[Nr].valid;
  assign out_result_hi = st[Nr][127:64];
  assign out_result_lo = st[Nr][63:0];
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// AES block cipher testbench
// The test first sends a table of known-answer and edge-case blocks, and then
// random blocks under several key sizes, directions and keys, sent in bursts
// with random gaps or gapless. Each result is compared with a known answer
// from the table or with a prediction that the testbench computes itself.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int KeyWait   = 80;
  localparam int DrainWait = 30;
  localparam int IdleLimit = 1000;
  localparam int Phases    = 12;
  localparam int PhaseLen  = 138;

  typedef struct {
    logic [1:0]   ks;
    logic         dir;
    logic [255:0] key;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic         typed;
    logic [127:0] known;
  } vec_t;

  logic        clk, rst_n, start, busy, out_valid, cfg_we;
  logic [63:0] in_block_hi, in_block_lo, out_result_hi, out_result_lo, cfg_data;
  logic [2:0]  cfg_index;

  logic         next_typed;
  logic [127:0] next_known;
  logic [1:0]   cur_ks;
  logic         cur_dir;
  logic [255:0] cur_key;
  logic [7:0]   inv_tab [256];
  logic [127:0] pending_blocks [$];
  int           errors = 0;
  int           idle_cnt = 0;
  int           burst_left;
  logic         gapless;

  aes_block_cipher_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic abc_pkg::word_t sub_w(input abc_pkg::word_t w);
    abc_pkg::word_t r;
    for (int j = 0; j < 4; j++) r[31-8*j -: 8] = abc_pkg::SBOX[w[31-8*j -: 8]];
    return r;
  endfunction

  function automatic abc_pkg::block_t sub_blk(input abc_pkg::block_t s, input logic inv);
    abc_pkg::block_t t;
    for (int i = 0; i < 16; i++)
      t[127-8*i -: 8] = inv ? inv_tab[s[127-8*i -: 8]] : abc_pkg::SBOX[s[127-8*i -: 8]];
    return t;
  endfunction

  function automatic abc_pkg::block_t shift_blk(input abc_pkg::block_t s, input logic inv);
    abc_pkg::block_t t;
    int o, p;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o = r + 4 * ((c + r) & 3);
        p = r + 4 * c;
        if (inv) t[127-8*o -: 8] = s[127-8*p -: 8];
        else t[127-8*p -: 8] = s[127-8*o -: 8];
      end
    end
    return t;
  endfunction

  function automatic abc_pkg::block_t mix_blk(input abc_pkg::block_t s, input logic inv);
    abc_pkg::block_t t;
    logic [7:0] m [4];
    logic [7:0] v;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gmul(s[127-8*(4*c+k) -: 8], m[(k + 4 - r) & 3]);
        t[127-8*(4*c+r) -: 8] = v;
      end
    end
    return t;
  endfunction

  function automatic abc_pkg::block_t aes_expect(input abc_pkg::block_t blk,
                                                 input logic [1:0] ks,
                                                 input logic dir, input logic [255:0] key);
    abc_pkg::word_t  w [60];
    abc_pkg::block_t rkey [15];
    abc_pkg::block_t s;
    abc_pkg::word_t  t;
    int nk, nr;
    if (ks[1]) begin
      nk = 8; nr = 14;
    end else if (ks == 2'd1) begin
      nk = 6; nr = 12;
    end else begin
      nk = 4; nr = 10;
    end
    for (int i = 0; i < 4 * (nr + 1); i++) begin
      if (i < nk) begin
        w[i] = key[255-32*i -: 32];
      end else begin
        t = w[i-1];
        if (i % nk == 0)
          t = sub_w({t[23:0], t[31:24]}) ^ {abc_pkg::RCON[(i / nk) % 11], 24'h0};
        else if (nk == 8 && i % nk == 4) t = sub_w(t);
        w[i] = w[i-nk] ^ t;
      end
    end
    for (int r = 0; r <= nr; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    if (dir) begin
      s = blk ^ rkey[nr];
      for (int r = nr - 1; r >= 1; r--)
        s = mix_blk(sub_blk(shift_blk(s, 1'b1), 1'b1) ^ rkey[r], 1'b1);
      s = sub_blk(shift_blk(s, 1'b1), 1'b1) ^ rkey[0];
    end else begin
      s = blk ^ rkey[0];
      for (int r = 1; r < nr; r++)
        s = mix_blk(shift_blk(sub_blk(s, 1'b0), 1'b0), 1'b0) ^ rkey[r];
      s = shift_blk(sub_blk(s, 1'b0), 1'b0) ^ rkey[nr];
    end
    return s;
  endfunction

  task automatic report_miss(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    $display("mismatch %s: expected %h got %h", what, want, got);
    errors++;
  endtask

  // record each accepted beat with its expected block
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      if (next_typed) pending_blocks.push_back(next_known);
      else pending_blocks.push_back(
        aes_expect({in_block_hi, in_block_lo}, cur_ks, cur_dir, cur_key));
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_valid) begin
      if (pending_blocks.size() == 0) begin
        report_miss("unexpected beat", 64'h0, out_result_hi);
      end else begin
        want = pending_blocks.pop_front();
        if (out_result_hi !== want[127:64]) report_miss("result_hi", want[127:64], out_result_hi);
        if (out_result_lo !== want[63:0]) report_miss("result_lo", want[63:0], out_result_lo);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [1:0] ks, input logic dir, input logic [255:0] key);
    drain();
    write_reg(abc_pkg::CFG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | 64'(ks));
    write_reg(abc_pkg::CFG_DIRECTION, {$urandom, $urandom} & ~64'h1 | 64'(dir));
    write_reg(abc_pkg::CFG_KEY_WORD0, key[255:192]);
    write_reg(abc_pkg::CFG_KEY_WORD1, key[191:128]);
    write_reg(abc_pkg::CFG_KEY_WORD2, key[127:64]);
    write_reg(abc_pkg::CFG_KEY_WORD3, key[63:0]);
    write_reg(CFG_SPARE_LO, {$urandom, $urandom});
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    cfg_we <= 1'b0;
    cur_ks  = ks;
    cur_dir = dir;
    cur_key = key;
    repeat (KeyWait) @(posedge clk);
  endtask

  // present one beat and hold until it is taken
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic typed, input logic [127:0] known);
    start       <= 1'b1;
    in_block_hi <= hi;
    in_block_lo <= lo;
    next_typed  <= typed;
    next_known  <= known;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (gapless) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 10);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = $urandom_range(1, 50);
  endtask

  vec_t table_v [] = '{
    '{2'd0, 1'b0, 256'h0, 64'h0, 64'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{2'd0, 1'b0, 256'h0, '1, '1, 1'b0, 128'h0},
    '{2'd0, 1'b0, {128'h000102030405060708090a0b0c0d0e0f, 128'h0},
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{2'd0, 1'b0, {128'h000102030405060708090a0b0c0d0e0f, ~128'h0},
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{2'd0, 1'b1, {128'h000102030405060708090a0b0c0d0e0f, 128'h0},
      64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
      128'h00112233445566778899aabbccddeeff},
    '{2'd1, 1'b0, {192'h000102030405060708090a0b0c0d0e0f1011121314151617, 64'h0},
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'hdda97ca4864cdfe06eaf70a0ec0d7191},
    '{2'd1, 1'b0, {192'h000102030405060708090a0b0c0d0e0f1011121314151617, ~64'h0},
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'hdda97ca4864cdfe06eaf70a0ec0d7191},
    '{2'd1, 1'b1, {192'h000102030405060708090a0b0c0d0e0f1011121314151617, 64'h0},
      64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b1,
      128'h00112233445566778899aabbccddeeff},
    '{2'd2, 1'b0,
      256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f,
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'h8ea2b7ca516745bfeafc49904b496089},
    '{2'd2, 1'b1,
      256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f,
      64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
      128'h00112233445566778899aabbccddeeff},
    '{2'd2, 1'b1,
      256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f,
      '1, 64'h0, 1'b0, 128'h0},
    '{2'd3, 1'b0,
      256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f,
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'h8ea2b7ca516745bfeafc49904b496089},
    '{2'd3, 1'b1, '1, '1, '1, 1'b0, 128'h0},
    '{2'd3, 1'b1, '1, 64'h0, '1, 1'b0, 128'h0},
    '{2'd1, 1'b1, '1, 64'h8000000000000001, 64'h0000000000000001, 1'b0, 128'h0},
    '{2'd0, 1'b1, '1, 64'h0, 64'h0, 1'b0, 128'h0}
  };

  initial begin
    logic [255:0] key;
    logic [63:0]  hi, lo;
    for (int i = 0; i < 256; i++) inv_tab[abc_pkg::SBOX[i]] = 8'(i);
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = abc_pkg::CFG_KEY_SIZE;
    cfg_data = 64'h0; in_block_hi = 64'h0; in_block_lo = 64'h0;
    next_typed = 1'b0; next_known = 128'h0;
    cur_ks = 2'd0; cur_dir = 1'b0; cur_key = 256'h0;
    burst_left = 0; gapless = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (KeyWait) @(posedge clk);

    foreach (table_v[i]) begin
      if (table_v[i].ks != cur_ks || table_v[i].dir != cur_dir || table_v[i].key != cur_key)
        load_config(table_v[i].ks, table_v[i].dir, table_v[i].key);
      send_block(table_v[i].hi, table_v[i].lo, table_v[i].typed, table_v[i].known);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      if (ph == 0) key = '0;
      else if (ph == 1) key = '1;
      else key = {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
      load_config(2'(ph % 4), 1'((ph / 4) % 2), key);
      gapless = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseLen; n++) begin
        case ($urandom_range(0, 15))
          0: begin hi = '0; lo = '0; end
          1: begin hi = '1; lo = '1; end
          default: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
        endcase
        send_block(hi, lo, 1'b0, 128'h0);
        // drop to idle midway until everything is back
        if (n == PhaseLen / 2 && ph == 5) drain();
        else pace();
      end
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
